// File: sv/correlation_hole_structure_factor_core_defines.svh
// assertion macros shared by the correlation hole structure factor rtl
`ifndef CORRELATION_HOLE_STRUCTURE_FACTOR_CORE_DEFINES_SVH
`define CORRELATION_HOLE_STRUCTURE_FACTOR_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk and disabled in reset
`define CHSF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk and disabled in reset
`define CHSF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/chsf_pkg.sv
// shared constants, register codes and series divisors for the structure factor core
package chsf_pkg;

    localparam int unsigned Q_W   = 24;
    localparam int unsigned ETA_W = 16;
    localparam int unsigned RAD_W = 20;
    localparam int unsigned CFG_W = 20;
    localparam int unsigned X_W   = 44;
    localparam int unsigned Y_W   = 32;

    // register indexes
    localparam logic REG_HOLE_FRACTION = 1'b0;
    localparam logic REG_HOLE_RADIUS   = 1'b1;

    localparam logic [ETA_W-1:0] HOLE_FRACTION_RST = 16'd0;
    localparam logic [RAD_W-1:0] HOLE_RADIUS_RST   = 20'd256;

    // 2^64 / (2 pi), split into halves
    localparam logic [31:0] TURN_K_LO = 32'h9391_054A;
    localparam logic [31:0] TURN_K_HI = 32'h28BE_60DB;

    localparam logic [31:0] TWO_PI_Q28 = 32'd1686629713;
    localparam logic [31:0] ONE_Q31    = 32'h8000_0000;
    localparam logic [31:0] OCTANT_Q31 = 32'd1686629713;
    localparam logic [37:0] HALF_QUAD  = 38'h20_0000_0000;

    // series kinds
    localparam int unsigned SERIES_HOLE = 0;
    localparam int unsigned SERIES_SIN  = 1;
    localparam int unsigned SERIES_COS  = 2;

    // divisor of term k (from 1) of each series
    function automatic int unsigned series_div(input int unsigned kind, input int unsigned k);
        int unsigned dv;
        case (kind)
            SERIES_HOLE: dv = (2 * k) * (2 * k + 3);
            SERIES_SIN:  dv = (2 * k) * (2 * k + 1);
            default:     dv = (2 * k - 1) * (2 * k);
        endcase
        return dv;
    endfunction

endpackage

// File: sv/chsf_delay.sv
// enable-gated shift line that aligns payload between pipeline branches
module chsf_delay #(
    parameter int unsigned W = 1,
    parameter int unsigned D = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] line_reg [0:D-1];

    for (genvar j = 0; j < D; j++) begin : g_tap
        if (j == 0) begin : g_first
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    line_reg[j] <= d;
                end
            end
        end else begin : g_rest
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    line_reg[j] <= line_reg[j-1];
                end
            end
        end
    end

    assign q = line_reg[D-1];

endmodule

// File: sv/chsf_taylor.sv
// pipelined alternating power series, two stages per term
module chsf_taylor #(
    parameter int unsigned KIND   = 0,
    parameter int unsigned NTERMS = 6
) (
    input  logic               clk,
    input  logic               en,
    input  logic [31:0]        first,
    input  logic [31:0]        sq,
    output logic signed [33:0] sum
);

    logic [31:0]        tin      [0:NTERMS-1];
    logic signed [33:0] accin    [0:NTERMS-1];
    logic [31:0]        sqin     [0:NTERMS-1];
    logic [31:0]        tout     [0:NTERMS-1];
    logic signed [33:0] accout   [0:NTERMS-1];
    logic [31:0]        va_reg   [0:NTERMS-1];
    logic signed [33:0] acca_reg [0:NTERMS-1];
    logic [31:0]        sqa_reg  [0:NTERMS-1];
    logic [64:0]        pb_reg   [0:NTERMS-1];
    logic signed [33:0] accb_reg [0:NTERMS-1];
    logic [31:0]        sqb_reg  [0:NTERMS-2];

    assign tin[0]   = first;
    assign accin[0] = $signed({2'b00, first});
    assign sqin[0]  = sq;

    for (genvar j = 0; j < NTERMS; j++) begin : g_term
        localparam int unsigned DV = chsf_pkg::series_div(KIND, j + 1);
        localparam int unsigned SH = 32 + $clog2(DV);
        localparam logic [32:0] MUL = 33'(((64'd1 << SH) + 64'(DV) - 64'd1) / 64'(DV));

        logic [63:0] sqprod;
        logic [31:0] va_next;

        assign sqprod  = 64'(tin[j]) * 64'(sqin[j]);
        assign va_next = 32'((sqprod + (64'd1 << 30)) >> 31);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                va_reg[j]   <= va_next;
                acca_reg[j] <= accin[j];
                sqa_reg[j]  <= sqin[j];
                pb_reg[j]   <= 65'(va_reg[j]) * 65'(MUL);
                accb_reg[j] <= acca_reg[j];
            end
        end

        // exact quotient by reciprocal multiply
        assign tout[j] = 32'(pb_reg[j] >> SH);

        if ((j % 2) == 0) begin : g_sub
            assign accout[j] = accb_reg[j] - $signed({2'b00, tout[j]});
        end else begin : g_add
            assign accout[j] = accb_reg[j] + $signed({2'b00, tout[j]});
        end

        if (j < NTERMS - 1) begin : g_link
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sqb_reg[j] <= sqa_reg[j];
                end
            end
            assign tin[j+1]   = tout[j];
            assign accin[j+1] = accout[j];
            assign sqin[j+1]  = sqb_reg[j];
        end
    end

    assign sum = accout[NTERMS-1];

endmodule

// File: sv/chsf_recip.sv
// pipelined restoring divider, one quotient bit per stage: floor((2^59 + den/2) / den)
module chsf_recip (
    input  logic                        clk,
    input  logic                        en,
    input  logic [chsf_pkg::X_W-1:0]    den,
    output logic [chsf_pkg::Y_W-1:0]    quo
);

    localparam int unsigned STEPS = chsf_pkg::Y_W;
    localparam int unsigned XW    = chsf_pkg::X_W;

    logic [59:0]   num;
    logic [XW-1:0] remin  [0:STEPS-1];
    logic [XW-1:0] denin  [0:STEPS-1];
    logic [31:0]   nloin  [0:STEPS-1];
    logic [31:0]   quoin  [0:STEPS-1];
    logic [XW-1:0] rem_reg [0:STEPS-2];
    logic [XW-1:0] den_reg [0:STEPS-2];
    logic [31:0]   nlo_reg [0:STEPS-2];
    logic [31:0]   quo_reg [0:STEPS-1];

    assign num      = {1'b1, 59'(den >> 1)};
    assign remin[0] = XW'(num[59:32]);
    assign denin[0] = den;
    assign nloin[0] = num[31:0];
    assign quoin[0] = 32'd0;

    for (genvar j = 0; j < STEPS; j++) begin : g_step
        logic [XW:0]   trial;
        logic          ge;
        logic [XW-1:0] rem_next;

        assign trial    = {remin[j], nloin[j][31]};
        assign ge       = trial >= {1'b0, denin[j]};
        assign rem_next = ge ? XW'(trial - {1'b0, denin[j]}) : trial[XW-1:0];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[j] <= {quoin[j][30:0], ge};
            end
        end

        if (j < STEPS - 1) begin : g_link
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j] <= rem_next;
                    den_reg[j] <= denin[j];
                    nlo_reg[j] <= {nloin[j][30:0], 1'b0};
                end
            end
            assign remin[j+1] = rem_reg[j];
            assign denin[j+1] = den_reg[j];
            assign nloin[j+1] = nlo_reg[j];
            assign quoin[j+1] = quo_reg[j];
        end
    end

    assign quo = quo_reg[STEPS-1];

endmodule

// File: sv/correlation_hole_structure_factor_core.sv
// 37 register stages from request accept to result valid
// throughput: one request per cycle; a stalled result freezes the whole pipeline
// depth is set by the 32-stage reciprocal divider on the large-x path
// reset clears all valid bits and loads hole_fraction = 0, hole_radius = 1.0
// top level of the correlation hole structure factor pipeline
`include "correlation_hole_structure_factor_core_defines.svh"

module correlation_hole_structure_factor_core #(
    parameter int unsigned OUT_FRAC_BITS = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [chsf_pkg::Q_W-1:0]      scatter_vector,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [OUT_FRAC_BITS:0]        structure_factor,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [chsf_pkg::CFG_W-1:0]    cfg_data
);

    localparam int unsigned LAT = 37;
    localparam int unsigned SH  = 31 - OUT_FRAC_BITS;
    localparam logic [38:0] OUT_MAX = 39'((40'd1 << (OUT_FRAC_BITS + 1)) - 40'd1);

    // configuration registers
    logic [chsf_pkg::ETA_W-1:0] hole_fraction_reg;
    logic [chsf_pkg::RAD_W-1:0] hole_radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hole_fraction_reg <= chsf_pkg::HOLE_FRACTION_RST;
            hole_radius_reg   <= chsf_pkg::HOLE_RADIUS_RST;
        end else if (cfg_we)
        begin
            unique case (cfg_index)
                chsf_pkg::REG_HOLE_FRACTION: hole_fraction_reg <= cfg_data[15:0];
                chsf_pkg::REG_HOLE_RADIUS:   hole_radius_reg   <= cfg_data;
            endcase
        end
    end

    // valid bits; the whole pipe advances unless the output is held
    logic [LAT-1:0] vld_reg;
    logic           en;

    assign en       = ~vld_reg[LAT-1] | out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    // stage 1: x = q * h in Q16.28
    logic [43:0] x_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= 44'(scatter_vector) * 44'(hole_radius_reg);
        end
    end

    // small-x flag rides along to the select stage
    logic is_small;
    logic is_small_d;

    assign is_small = ~|x_reg[43:28];

    chsf_delay #(.W(1), .D(33)) u_small_dly (
        .clk (clk),
        .en  (en),
        .d   (is_small),
        .q   (is_small_d)
    );

    // small-x branch: x^2 then the series for 3(sin x - x cos x)/x^3
    logic [30:0] xq;
    logic [63:0] xsq;
    logic [31:0] x2_reg;

    assign xq  = {x_reg[27:0], 3'b000};
    assign xsq = 64'(xq) * 64'(xq);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x2_reg <= 32'((xsq + (64'd1 << 30)) >> 31);
        end
    end

    logic signed [33:0] g_small;
    logic [33:0]        g_small_d;

    chsf_taylor #(.KIND(chsf_pkg::SERIES_HOLE), .NTERMS(6)) u_hole (
        .clk   (clk),
        .en    (en),
        .first (chsf_pkg::ONE_Q31),
        .sq    (x2_reg),
        .sum   (g_small)
    );

    chsf_delay #(.W(34), .D(20)) u_gsmall_dly (
        .clk (clk),
        .en  (en),
        .d   (g_small),
        .q   (g_small_d)
    );

    // large-x branch: phase in turns, x * 2^64/(2 pi), bits 52..91
    logic [53:0] pll_reg;
    logic [53:0] plh_reg;
    logic [53:0] phl_reg;
    logic [53:0] phh_reg;
    logic [76:0] sum_lo_reg;
    logic [76:0] sum_hi_reg;
    logic [91:0] full_prod;
    logic [39:0] phase_reg;

    assign full_prod = 92'(sum_lo_reg) + (92'(sum_hi_reg) << 32);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pll_reg    <= 54'(x_reg[21:0])  * 54'(chsf_pkg::TURN_K_LO);
            plh_reg    <= 54'(x_reg[21:0])  * 54'(chsf_pkg::TURN_K_HI);
            phl_reg    <= 54'(x_reg[43:22]) * 54'(chsf_pkg::TURN_K_LO);
            phh_reg    <= 54'(x_reg[43:22]) * 54'(chsf_pkg::TURN_K_HI);
            sum_lo_reg <= 77'(pll_reg) + (77'(phl_reg) << 22);
            sum_hi_reg <= 77'(plh_reg) + (77'(phh_reg) << 22);
            phase_reg  <= full_prod[91:52];
        end
    end

    // fold the phase into the first octant of its quadrant
    logic [37:0] r_frac;
    logic        swap_next;
    logic [37:0] rr_reg;
    logic        swap_reg;
    logic [1:0]  quad_reg;

    assign r_frac    = phase_reg[37:0];
    assign swap_next = r_frac > chsf_pkg::HALF_QUAD;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rr_reg   <= swap_next ? 38'(39'h40_0000_0000 - 39'(r_frac)) : r_frac;
            swap_reg <= swap_next;
            quad_reg <= phase_reg[39:38];
        end
    end

    logic [2:0] qs_d;

    chsf_delay #(.W(3), .D(15)) u_quad_dly (
        .clk (clk),
        .en  (en),
        .d   ({swap_reg, quad_reg}),
        .q   (qs_d)
    );

    // angle in Q31 radians and its square
    logic [63:0] th_prod;
    logic [31:0] th_reg;
    logic [63:0] thsq;
    logic [31:0] th2_reg;
    logic [31:0] thd_reg;

    assign th_prod = 64'(rr_reg[37:5]) * 64'(chsf_pkg::TWO_PI_Q28);
    assign thsq    = 64'(th_reg) * 64'(th_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            th_reg  <= 32'((th_prod + (64'd1 << 31)) >> 32);
            th2_reg <= 32'((thsq + (64'd1 << 30)) >> 31);
            thd_reg <= th_reg;
        end
    end

    logic signed [33:0] sin_oct;
    logic signed [33:0] cos_oct;
    logic [33:0]        sin_d;
    logic [33:0]        cos_d;

    chsf_taylor #(.KIND(chsf_pkg::SERIES_SIN), .NTERMS(5)) u_sin (
        .clk   (clk),
        .en    (en),
        .first (thd_reg),
        .sq    (th2_reg),
        .sum   (sin_oct)
    );

    chsf_taylor #(.KIND(chsf_pkg::SERIES_COS), .NTERMS(6)) u_cos (
        .clk   (clk),
        .en    (en),
        .first (chsf_pkg::ONE_Q31),
        .sq    (th2_reg),
        .sum   (cos_oct)
    );

    chsf_delay #(.W(34), .D(3)) u_sin_dly (
        .clk (clk),
        .en  (en),
        .d   (sin_oct),
        .q   (sin_d)
    );

    chsf_delay #(.W(34), .D(1)) u_cos_dly (
        .clk (clk),
        .en  (en),
        .d   (cos_oct),
        .q   (cos_d)
    );

    // undo the octant swap and map to the quadrant
    logic signed [33:0] sa;
    logic signed [33:0] ca;
    logic signed [33:0] s_map_next;
    logic signed [33:0] c_map_next;
    logic signed [33:0] s_map_reg;
    logic signed [33:0] c_map_reg;

    always_comb
    begin
        sa = qs_d[2] ? $signed(cos_d) : $signed(sin_d);
        ca = qs_d[2] ? $signed(sin_d) : $signed(cos_d);
        case (qs_d[1:0])
            2'd0:
            begin
                s_map_next = sa;
                c_map_next = ca;
            end
            2'd1:
            begin
                s_map_next = ca;
                c_map_next = -sa;
            end
            2'd2:
            begin
                s_map_next = -sa;
                c_map_next = -ca;
            end
            default:
            begin
                s_map_next = -ca;
                c_map_next = sa;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_map_reg <= s_map_next;
            c_map_reg <= c_map_next;
        end
    end

    logic [67:0] sc_d;

    chsf_delay #(.W(68), .D(12)) u_sc_dly (
        .clk (clk),
        .en  (en),
        .d   ({s_map_reg, c_map_reg}),
        .q   (sc_d)
    );

    // 1/x in Q31 from the divider pipe
    logic [31:0] y;

    chsf_recip u_recip (
        .clk (clk),
        .en  (en),
        .den (x_reg),
        .quo (y)
    );

    // d = sin/x - cos, and 1/x^2
    logic signed [33:0] s_al;
    logic signed [33:0] c_al;
    logic               s_neg;
    logic [33:0]        s_mag;
    logic [65:0]        sy_prod;
    logic [34:0]        sy_rnd;
    logic signed [35:0] sy_sgn;
    logic [63:0]        yy_prod;
    logic [31:0]        y2_reg;
    logic signed [35:0] d_reg;

    assign s_al    = $signed(sc_d[67:34]);
    assign c_al    = $signed(sc_d[33:0]);
    assign s_neg   = s_al[33];
    assign s_mag   = s_neg ? 34'(-s_al) : 34'(s_al);
    assign sy_prod = 66'(s_mag) * 66'(y);
    assign sy_rnd  = 35'((sy_prod + (66'd1 << 30)) >> 31);
    assign sy_sgn  = s_neg ? -$signed({1'b0, sy_rnd}) : $signed({1'b0, sy_rnd});
    assign yy_prod = 64'(y) * 64'(y);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y2_reg <= 32'((yy_prod + (64'd1 << 30)) >> 31);
            d_reg  <= sy_sgn - 36'(c_al);
        end
    end

    // g = 3 * d / x^2 on the large branch, else the series value
    logic               d_neg;
    logic [35:0]        d_mag;
    logic [67:0]        dy_prod;
    logic [38:0]        dy_rnd;
    logic [38:0]        dy_x3;
    logic signed [39:0] g_large;
    logic signed [39:0] g_reg;

    assign d_neg   = d_reg[35];
    assign d_mag   = d_neg ? 36'(-d_reg) : 36'(d_reg);
    assign dy_prod = 68'(d_mag) * 68'(y2_reg);
    assign dy_rnd  = 39'((dy_prod + (68'd1 << 30)) >> 31);
    assign dy_x3   = (dy_rnd << 1) + dy_rnd;
    assign g_large = d_neg ? -$signed({1'b0, dy_x3}) : $signed({1'b0, dy_x3});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_reg <= is_small_d ? 40'($signed(g_small_d)) : g_large;
        end
    end

    // S = 1 - eta * g in Q31
    logic               g_neg;
    logic [39:0]        g_mag;
    logic [55:0]        ge_prod;
    logic [39:0]        ge_rnd;
    logic signed [41:0] s31_reg;

    assign g_neg   = g_reg[39];
    assign g_mag   = g_neg ? 40'(-g_reg) : 40'(g_reg);
    assign ge_prod = 56'(g_mag) * 56'(hole_fraction_reg);
    assign ge_rnd  = 40'((ge_prod + (56'd1 << 15)) >> 16);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s31_reg <= g_neg
                ? 42'($signed({1'b0, chsf_pkg::ONE_Q31})) + 42'($signed({1'b0, ge_rnd}))
                : 42'($signed({1'b0, chsf_pkg::ONE_Q31})) - 42'($signed({1'b0, ge_rnd}));
        end
    end

    // clamp at zero, round to the output grid, saturate below two
    logic [40:0]          s_pos;
    logic [38:0]          s_out;
    logic [OUT_FRAC_BITS:0] out_reg;

    assign s_pos = s31_reg[41] ? 41'd0 : 41'(s31_reg);
    assign s_out = 39'((s_pos + (41'd1 << (SH - 1))) >> SH);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= (s_out > OUT_MAX) ? OUT_MAX[OUT_FRAC_BITS:0] : s_out[OUT_FRAC_BITS:0];
        end
    end

    assign out_valid        = vld_reg[LAT-1];
    assign structure_factor = out_reg;

    `CHSF_ASSERT_NXT(a_stall_hold, vld_reg[LAT-1] && !out_ready, $stable(vld_reg) && $stable(out_reg), "pipeline moved under a held result")
    `CHSF_ASSERT_IMP(a_fold_range, vld_reg[4], rr_reg <= chsf_pkg::HALF_QUAD, "folded phase above one octant")
    `CHSF_ASSERT_IMP(a_theta_range, vld_reg[5], th_reg <= chsf_pkg::OCTANT_Q31, "angle above pi/4")

endmodule
